// ===== rtl/acl_fmc_pkg.sv =====
// Shared types and constants for the five-tuple first-match ACL classifier.
// Depends on nothing; imported by the controller, the datapath and the top level.
package acl_fmc_pkg;

  localparam int SLOT_W  = 6;
  localparam int MAX_SLOTS = 2 ** SLOT_W;

  localparam logic OP_CLASSIFY = 1'b0;
  localparam logic OP_WRITE    = 1'b1;

  // One stored rule.
  typedef struct packed {
    logic [31:0] src_val;
    logic [31:0] src_mask;
    logic [31:0] dst_val;
    logic [31:0] dst_mask;
    logic [15:0] sp_lo;
    logic [15:0] sp_hi;
    logic [15:0] dp_lo;
    logic [15:0] dp_hi;
    logic [7:0]  proto_val;
    logic [7:0]  proto_msk;
    logic        permit;
  } rule_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic write;
    logic rd_en;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;
  } sts_t;

endpackage

// ===== rtl/acl_fmc_ctrl.sv =====
// Controller of the ACL classifier: accepts requests and sequences the rule scan.
// Depends on acl_fmc_pkg for the command and status types.
module acl_fmc_ctrl
  import acl_fmc_pkg::*;
#(
  parameter int MEM_DEPTH = 64,
  parameter int IDX_W     = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             operation,
  output logic             busy,
  output cmd_t             cmd,
  output logic [IDX_W-1:0] rd_addr,
  input  sts_t             sts
);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MEM_DEPTH - 1);

  state_t           state;
  logic [IDX_W-1:0] rd_idx;
  logic             issue_done;
  logic             eval_ok;
  logic             eval_last;
  logic             accept;

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;
  assign rd_addr = rd_idx;

  always_comb begin
    cmd         = '0;
    cmd.capture = accept && (operation == OP_CLASSIFY);
    cmd.write   = accept && (operation == OP_WRITE);
    cmd.rd_en   = (state == ST_SCAN) && !issue_done;
    cmd.finish  = (state == ST_SCAN) && eval_ok && (sts.hit || eval_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      rd_idx     <= '0;
      issue_done <= 1'b0;
      eval_ok    <= 1'b0;
      eval_last  <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          eval_ok <= 1'b0;
          if (cmd.capture) begin
            state      <= ST_SCAN;
            rd_idx     <= '0;
            issue_done <= 1'b0;
          end
        end
        ST_SCAN: begin
          // Reads run one slot ahead of the compare on the registered entry.
          eval_ok   <= cmd.rd_en;
          eval_last <= (rd_idx == LAST_IDX);
          if (cmd.rd_en) begin
            if (rd_idx == LAST_IDX) begin
              issue_done <= 1'b1;
            end else begin
              rd_idx <= rd_idx + 1'b1;
            end
          end
          if (cmd.finish) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_idle_no_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !cmd.rd_en && !cmd.finish)
    else $error("rule read or finish issued while idle");

  a_finish_to_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (state == ST_IDLE))
    else $error("controller stayed busy after finishing a scan");

  a_write_when_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.write || cmd.capture) |-> (state == ST_IDLE) && !(cmd.write && cmd.capture))
    else $error("request taken while busy or decoded twice");

  a_finish_needs_eval: assert property (@(posedge clk) disable iff (rst)
    (eval_ok && eval_last && state == ST_SCAN) |-> cmd.finish)
    else $error("scan passed the last slot without a verdict");

endmodule

// ===== rtl/acl_fmc_datapath.sv =====
// Datapath of the ACL classifier: rule memory, valid bits, rule compare,
// verdict counters and result registers. Depends on acl_fmc_pkg.
module acl_fmc_datapath
  import acl_fmc_pkg::*;
#(
  parameter int MEM_DEPTH = 64,
  parameter int IDX_W     = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  input  logic [IDX_W-1:0]  rd_addr,
  output sts_t              sts,
  input  logic [SLOT_W-1:0] rule_slot,
  input  logic [31:0]       src_address,
  input  logic [31:0]       src_mask,
  input  logic [31:0]       dst_address,
  input  logic [31:0]       dst_mask,
  input  logic [15:0]       src_l4_port,
  input  logic [15:0]       src_port_top,
  input  logic [15:0]       dst_l4_port,
  input  logic [15:0]       dst_port_top,
  input  logic [7:0]        protocol,
  input  logic [8:0]        protocol_mask_action,
  output logic              result_valid,
  output logic              verdict_permit,
  output logic              rule_matched,
  output logic [SLOT_W-1:0] match_slot,
  output logic [31:0]       permit_total,
  output logic [31:0]       deny_total
);

  rule_t            rule_mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] valid;
  rule_t            rdata;
  logic             rvalid;
  logic [IDX_W-1:0] eval_slot;

  logic [31:0] pkt_sa;
  logic [31:0] pkt_da;
  logic [15:0] pkt_sp;
  logic [15:0] pkt_dp;
  logic [7:0]  pkt_pr;

  logic [31:0] permit_cnt;
  logic [31:0] deny_cnt;
  logic [31:0] permit_cnt_next;
  logic [31:0] deny_cnt_next;

  logic  wr_ok;
  rule_t wr_rule;
  logic  hit;
  logic  permit;

  assign wr_ok = cmd.write && (int'(rule_slot) < MEM_DEPTH);

  always_comb begin
    wr_rule.src_val    = src_address;
    wr_rule.src_mask   = src_mask;
    wr_rule.dst_val    = dst_address;
    wr_rule.dst_mask   = dst_mask;
    wr_rule.sp_lo      = src_l4_port;
    wr_rule.sp_hi      = src_port_top;
    wr_rule.dp_lo      = dst_l4_port;
    wr_rule.dp_hi      = dst_port_top;
    wr_rule.proto_val  = protocol;
    wr_rule.proto_msk  = protocol_mask_action[7:0];
    wr_rule.permit     = protocol_mask_action[8];
  end

  // Rule memory: one write port for rule loads, one registered read for the scan.
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      rule_mem[rule_slot[IDX_W-1:0]] <= wr_rule;
    end
    if (cmd.rd_en) begin
      rdata     <= rule_mem[rd_addr];
      eval_slot <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rvalid <= 1'b0;
    end else begin
      if (wr_ok) begin
        valid[rule_slot[IDX_W-1:0]] <= 1'b1;
      end
      if (cmd.rd_en) begin
        rvalid <= valid[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pkt_sa <= src_address;
      pkt_da <= dst_address;
      pkt_sp <= src_l4_port;
      pkt_dp <= dst_l4_port;
      pkt_pr <= protocol;
    end
  end

  assign hit = rvalid
            && ((pkt_sa & rdata.src_mask) == rdata.src_val)
            && ((pkt_da & rdata.dst_mask) == rdata.dst_val)
            && (pkt_sp >= rdata.sp_lo) && (pkt_sp <= rdata.sp_hi)
            && (pkt_dp >= rdata.dp_lo) && (pkt_dp <= rdata.dp_hi)
            && ((pkt_pr & rdata.proto_msk) == rdata.proto_val);

  assign sts.hit = hit;
  assign permit  = hit && rdata.permit;

  always_comb begin
    permit_cnt_next = permit_cnt;
    deny_cnt_next   = deny_cnt;
    if (cmd.finish) begin
      if (permit) begin
        permit_cnt_next = permit_cnt + 32'd1;
      end else begin
        deny_cnt_next = deny_cnt + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      permit_cnt   <= '0;
      deny_cnt     <= '0;
      result_valid <= 1'b0;
    end else begin
      permit_cnt   <= permit_cnt_next;
      deny_cnt     <= deny_cnt_next;
      result_valid <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      verdict_permit <= permit;
      rule_matched   <= hit;
      match_slot     <= hit ? SLOT_W'(eval_slot) : '0;
      permit_total   <= permit_cnt_next;
      deny_total     <= deny_cnt_next;
    end
  end

  a_result_follows_finish: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(cmd.finish))
    else $error("result strobe without a finished scan");

  a_nomatch_is_deny: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !rule_matched) |-> (!verdict_permit && match_slot == '0))
    else $error("unmatched packet reported as permit or with a slot");

endmodule

// ===== rtl/acl_first_match_classifier_unit.sv =====
// Top level of the five-tuple first-match ACL classifier.
// Depends on acl_fmc_pkg, acl_fmc_ctrl and acl_fmc_datapath.
//
// Usage. A request is presented on the payload ports with start high; it is
// taken at a rising edge where start is high and busy is low. With operation
// set to write, the request loads the rule given by the payload into
// rule_slot and sets that slot valid; it keeps busy low and produces no
// result. Writes to a slot at or above NUM_RULES are dropped.
// With operation set to classify, the packet tuple is captured and the rules
// are scanned in slot order, one slot per cycle, from the single read port of
// the rule memory. The first valid matching rule gives the verdict; if none
// matches the packet is denied. A classify keeps busy high from the accepting
// edge until its result is shown, and stops its scan at the first match or,
// without one, after the last slot. The next request may be taken in the
// cycle that the result is shown.
// A result is on the result ports for exactly one cycle with result_valid
// high; the receiver has no way to stall it and must take it then.
// Reset clears every slot valid bit and both verdict counters; rule contents
// are not cleared, so the block is ready in the first cycle after reset.
module acl_first_match_classifier_unit
  import acl_fmc_pkg::*;
#(
  parameter int NUM_RULES = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              operation,
  input  logic [SLOT_W-1:0] rule_slot,
  input  logic [31:0]       src_address,
  input  logic [31:0]       src_mask,
  input  logic [31:0]       dst_address,
  input  logic [31:0]       dst_mask,
  input  logic [15:0]       src_l4_port,
  input  logic [15:0]       src_port_top,
  input  logic [15:0]       dst_l4_port,
  input  logic [15:0]       dst_port_top,
  input  logic [7:0]        protocol,
  input  logic [8:0]        protocol_mask_action,
  output logic              result_valid,
  output logic              verdict_permit,
  output logic              rule_matched,
  output logic [SLOT_W-1:0] match_slot,
  output logic [31:0]       permit_total,
  output logic [31:0]       deny_total
);

  // Slots above the reach of rule_slot can never be written, so the table
  // holds at most as many entries as the slot field can address.
  localparam int MEM_DEPTH = (NUM_RULES < MAX_SLOTS) ? NUM_RULES : MAX_SLOTS;
  localparam int IDX_W     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  cmd_t             cmd;
  sts_t             sts;
  logic [IDX_W-1:0] rd_addr;

  // The controller decodes requests and walks the slot index.
  acl_fmc_ctrl #(
    .MEM_DEPTH (MEM_DEPTH),
    .IDX_W     (IDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .busy      (busy),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .sts       (sts)
  );

  // The datapath stores rules, compares one entry a cycle and keeps counts.
  acl_fmc_datapath #(
    .MEM_DEPTH (MEM_DEPTH),
    .IDX_W     (IDX_W)
  ) u_datapath (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .rd_addr              (rd_addr),
    .sts                  (sts),
    .rule_slot            (rule_slot),
    .src_address          (src_address),
    .src_mask             (src_mask),
    .dst_address          (dst_address),
    .dst_mask             (dst_mask),
    .src_l4_port          (src_l4_port),
    .src_port_top         (src_port_top),
    .dst_l4_port          (dst_l4_port),
    .dst_port_top         (dst_port_top),
    .protocol             (protocol),
    .protocol_mask_action (protocol_mask_action),
    .result_valid         (result_valid),
    .verdict_permit       (verdict_permit),
    .rule_matched         (rule_matched),
    .match_slot           (match_slot),
    .permit_total         (permit_total),
    .deny_total           (deny_total)
  );

endmodule
